/* design/first_seen_tracking_table_defines.svh */
// ----------------------------------------------------------------------------
// First-seen tracking table assertion macros
// Shared concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FIRST_SEEN_TRACKING_TABLE_DEFINES_SVH
`define FIRST_SEEN_TRACKING_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define FST_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fst assertion failed");
`define FST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fst assertion failed");
`else
`define FST_ASSERT_SAME(label, clk, rst, ante, cons)
`define FST_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* design/fst_pkg.sv */
// ----------------------------------------------------------------------------
// First-seen tracking table package
// Transaction types, entry layout, opcodes and defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fst_pkg;

   localparam int          TableEntriesDefault = 32;
   localparam logic [31:0] ForgetResetValue    = 32'd600000;

   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_END    = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] now_ms;
      logic [63:0] area_key;
      logic [63:0] callsign;
   } req_type;

   typedef struct packed {
      logic [31:0] first_seen_ms;
      logic        newly_entered;
   } rsp_type;

   typedef struct packed {
      logic [63:0] callsign;
      logic [31:0] first_time;
      logic [31:0] last_time;
   } entry_type;

endpackage

/* design/fst_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/first_seen_tracking_table.sv */
// A lookup scans the entries in order from entry 0 until a hit; a miss scans every stored entry.
// Start round: a purge pass reads each entry and moves the last entry into each purged slot.
// End round and unused opcodes complete without leaving idle. One transaction at a time.
// Throughput is set by the single read port of the entry RAM.
// Synchronous reset empties the table at once (no clearing pass).
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// First-seen tracking table
// Keyed callsign table with first/last-seen times, aging and LRU eviction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "first_seen_tracking_table_defines.svh"

module first_seen_tracking_table #(
   parameter int TABLE_ENTRIES = fst_pkg::TableEntriesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fst_pkg::req_type req_data,
   output logic             rsp_valid,
   output fst_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);

   import fst_pkg::*;

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW-1:0] FullCount = CW'(TABLE_ENTRIES);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PURGE_RD,
      S_PURGE_CHK,
      S_PURGE_MOVE,
      S_LOOK
   } state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] pend_idx_ff, pend_idx_in;
   logic [IW-1:0] min_idx_ff, min_idx_in;
   logic [31:0]   min_last_ff, min_last_in;
   logic [63:0]   call_ff, call_in;
   logic [63:0]   key_ff, key_in;
   logic          key_valid_ff, key_valid_in;
   logic          baseline_ff, baseline_in;
   logic [31:0]   round_ff, round_in;
   logic [31:0]   forget_ff, forget_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          ram_wr_en;
   logic [IW-1:0] ram_wr_addr;
   entry_type     ram_wr_data;
   logic [IW-1:0] ram_rd_addr;
   entry_type     ram_rd_data;

   logic [CW-1:0] last_cnt;
   logic [31:0]   new_first;
   logic          accept;

   fst_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign accept    = start && (state_ff == S_IDLE);
   assign last_cnt  = count_ff - CW'(1);
   assign new_first = !baseline_ff ? 32'd0 : ((round_ff == 32'd0) ? 32'd1 : round_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      min_idx_in   = min_idx_ff;
      min_last_in  = min_last_ff;
      call_in      = call_ff;
      key_in       = key_ff;
      key_valid_in = key_valid_ff;
      baseline_in  = baseline_ff;
      round_in     = round_ff;
      forget_in    = csr_valid ? csr_data : forget_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff[IW-1:0];
      ram_wr_data  = ram_rd_data;
      ram_rd_addr  = idx_ff[IW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_data.opcode)
                  OP_START: begin
                     if (!key_valid_ff || (req_data.area_key != key_ff)) begin
                        key_in       = req_data.area_key;
                        key_valid_in = 1'b1;
                        count_in     = '0;
                        baseline_in  = 1'b0;
                     end
                     round_in = req_data.now_ms;
                     idx_in   = '0;
                     state_in = S_PURGE_RD;
                  end
                  OP_LOOKUP: begin
                     call_in  = req_data.callsign;
                     idx_in   = '0;
                     pend_in  = 1'b0;
                     state_in = S_LOOK;
                  end
                  OP_END: begin
                     baseline_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PURGE_RD: begin
            if (idx_ff >= count_ff) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_PURGE_CHK;
            end
         end
         S_PURGE_CHK: begin
            if ((round_ff - ram_rd_data.last_time) > forget_ff) begin
               ram_rd_addr = last_cnt[IW-1:0];
               state_in    = S_PURGE_MOVE;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_PURGE_RD;
            end
         end
         S_PURGE_MOVE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff[IW-1:0];
            ram_wr_data = ram_rd_data;
            count_in    = last_cnt;
            state_in    = S_PURGE_RD;
         end
         S_LOOK: begin
            if (pend_ff && (ram_rd_data.callsign == call_ff)) begin
               ram_wr_en              = 1'b1;
               ram_wr_addr            = pend_idx_ff;
               ram_wr_data.callsign   = call_ff;
               ram_wr_data.first_time = ram_rd_data.first_time;
               ram_wr_data.last_time  = round_ff;
               rsp_valid_in           = 1'b1;
               rsp_in.first_seen_ms   = ram_rd_data.first_time;
               rsp_in.newly_entered   = 1'b0;
               pend_in                = 1'b0;
               state_in               = S_IDLE;
            end else if (!pend_ff && (idx_ff >= count_ff)) begin
               ram_wr_en              = 1'b1;
               ram_wr_data.callsign   = call_ff;
               ram_wr_data.first_time = new_first;
               ram_wr_data.last_time  = round_ff;
               if (count_ff < FullCount) begin
                  ram_wr_addr = count_ff[IW-1:0];
                  count_in    = count_ff + CW'(1);
               end else begin
                  ram_wr_addr = min_idx_ff;
               end
               rsp_valid_in         = 1'b1;
               rsp_in.first_seen_ms = new_first;
               rsp_in.newly_entered = 1'b1;
               state_in             = S_IDLE;
            end else begin
               if (pend_ff && ((pend_idx_ff == '0) ||
                               (ram_rd_data.last_time < min_last_ff))) begin
                  min_idx_in  = pend_idx_ff;
                  min_last_in = ram_rd_data.last_time;
               end
               if (idx_ff < count_ff) begin
                  pend_in     = 1'b1;
                  pend_idx_in = idx_ff[IW-1:0];
                  idx_in      = idx_ff + CW'(1);
               end else begin
                  pend_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         key_ff       <= '0;
         key_valid_ff <= 1'b0;
         baseline_ff  <= 1'b0;
         round_ff     <= '0;
         forget_ff    <= ForgetResetValue;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         key_ff       <= key_in;
         key_valid_ff <= key_valid_in;
         baseline_ff  <= baseline_in;
         round_ff     <= round_in;
         forget_ff    <= forget_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_idx_ff <= pend_idx_in;
      min_idx_ff  <= min_idx_in;
      min_last_ff <= min_last_in;
      call_ff     <= call_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   `FST_ASSERT_SAME(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   `FST_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= FullCount)
   `FST_ASSERT_NEXT(a_lookup_busy, clock, reset, accept && (req_data.opcode == OP_LOOKUP), busy)
   `FST_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)

endmodule
